// File: hdl/ipvl_pkg.sv
package ipvl_pkg;

	localparam int ENTRIES   = 64;
	localparam int ADDR_BITS = 32;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int LEN_W     = $clog2(ADDR_BITS + 1);
	localparam int VIEW_W    = 8;
	localparam int REQ_W     = 2;
	localparam int PLEN_W    = 6;
	localparam int ADDR_IN_W = 32;
	localparam int STAT_W    = 3;
	localparam int ENT_W     = ADDR_BITS + LEN_W + VIEW_W;

	localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DEL    = 2'd2;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_DUP      = 3'd1,
		STAT_NOTFOUND = 3'd2,
		STAT_MISMATCH = 3'd3,
		STAT_FULL     = 3'd4,
		STAT_BADLEN   = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	function automatic logic [ADDR_BITS-1:0] len_mask(input logic [LEN_W-1:0] len);
		return ~({ADDR_BITS{1'b1}} >> len);
	endfunction

endpackage

// File: hdl/ipvl_req_if.sv
interface ipvl_req_if;
	import ipvl_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [REQ_W-1:0]     req_type;
	logic [ADDR_IN_W-1:0] address;
	logic [PLEN_W-1:0]    prefix_len;
	logic [VIEW_W-1:0]    view_id;

	modport source (output valid, output req_type, output address, output prefix_len,
		output view_id, input ready);
	modport sink (input valid, input req_type, input address, input prefix_len,
		input view_id, output ready);

endinterface

// File: hdl/ipvl_rsp_if.sv
interface ipvl_rsp_if;
	import ipvl_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic              found;
	logic [VIEW_W-1:0] result_view;

	modport source (output valid, output status, output found, output result_view,
		input ready);
	modport sink (input valid, input status, input found, input result_view,
		output ready);

endinterface

// File: hdl/ipvl_ram.sv
module ipvl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/ipv4_prefix_view_lookup.sv
// Lookup, add and delete scan all ENTRIES slots through one RAM read port and one
// shared masked compare, then a drain state and a finish state load the result.
// The block takes the next request in the cycle after the result is loaded; bad
// length add and delete requests and unknown requests skip the scan and go to the
// finish state. A stalled result holds the block.
// arst_n clears all valid marks and the control state; the entry RAM is not cleared.
module ipv4_prefix_view_lookup (
	input logic        clk,
	input logic        arst_n,
	ipvl_req_if.sink   req,
	ipvl_rsp_if.source rsp
);
	import ipvl_pkg::*;

	state_t state_q, state_d;

	logic [ENTRIES-1:0] entry_valid_q;

	logic [REQ_W-1:0]     req_q;
	logic [ADDR_BITS-1:0] key_q;
	logic [LEN_W-1:0]     len_q;
	logic [VIEW_W-1:0]    view_q;
	logic                 bad_len_q;

	logic [IDX_W-1:0] idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             ev_s1;

	logic              found_q;
	logic [LEN_W-1:0]  best_len_q;
	logic [VIEW_W-1:0] best_view_q;
	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [VIEW_W-1:0] hit_view_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;

	logic              out_vld_q;
	status_t           out_status_q;
	logic              out_found_q;
	logic [VIEW_W-1:0] out_view_q;

	logic                 in_acc;
	logic [ADDR_BITS-1:0] in_addr;
	logic [LEN_W-1:0]     in_len;
	logic                 in_bad_len;
	logic                 in_skip;

	logic             ram_re;
	logic             ram_we;
	logic [ENT_W-1:0] ram_wdata;
	logic [ENT_W-1:0] ram_rdata;

	logic [ADDR_BITS-1:0] ent_prefix;
	logic [LEN_W-1:0]     ent_len;
	logic [VIEW_W-1:0]    ent_view;
	logic                 cmp_eq;
	logic                 lk_take;
	logic                 ex_hit;

	logic    out_free;
	logic    fin_load;
	logic    del_clr;
	status_t fin_status;
	logic    fin_found;
	logic [VIEW_W-1:0] fin_view;

	assign in_acc     = req.valid && req.ready;
	assign in_addr    = req.address[ADDR_BITS-1:0];
	assign in_len     = req.prefix_len[LEN_W-1:0];
	assign in_bad_len = (req.prefix_len == '0) || (req.prefix_len > PLEN_W'(ADDR_BITS));
	assign in_skip    = !(req.req_type inside {REQ_LOOKUP, REQ_ADD, REQ_DEL})
		|| (in_bad_len && (req.req_type inside {REQ_ADD, REQ_DEL}));

	ipvl_ram #(
		.WIDTH(ENT_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_idx_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	assign ram_wdata  = {key_q, len_q, view_q};
	assign ent_prefix = ram_rdata[ENT_W-1 -: ADDR_BITS];
	assign ent_len    = ram_rdata[VIEW_W +: LEN_W];
	assign ent_view   = ram_rdata[VIEW_W-1:0];

	// shared compare: address or stored key masked to the entry's length
	assign cmp_eq  = vld_s1 && ev_s1 && ((key_q & len_mask(ent_len)) == ent_prefix);
	assign lk_take = cmp_eq && (!found_q || (ent_len > best_len_q));
	assign ex_hit  = cmp_eq && (ent_len == len_q);

	assign out_free = !out_vld_q || rsp.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = in_skip ? S_FINISH : S_SCAN;
				end
			end
			S_SCAN: begin
				if (idx_q == IDX_W'(ENTRIES - 1)) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready  = (state_q == S_IDLE);
		ram_re     = (state_q == S_SCAN);
		fin_load   = (state_q == S_FINISH) && out_free;
		fin_found  = 1'b0;
		fin_view   = '0;
		fin_status = STAT_OK;
		case (req_q)
			REQ_LOOKUP: begin
				fin_found = found_q;
				fin_view  = found_q ? best_view_q : '0;
			end
			REQ_ADD: begin
				if (bad_len_q) begin
					fin_status = STAT_BADLEN;
				end else if (hit_q) begin
					fin_status = STAT_DUP;
				end else if (!free_q) begin
					fin_status = STAT_FULL;
				end
			end
			REQ_DEL: begin
				if (bad_len_q) begin
					fin_status = STAT_BADLEN;
				end else if (!hit_q) begin
					fin_status = STAT_NOTFOUND;
				end else if (hit_view_q != view_q) begin
					fin_status = STAT_MISMATCH;
				end
			end
			default: begin
				fin_status = STAT_NOTFOUND;
			end
		endcase
		ram_we  = fin_load && (req_q == REQ_ADD) && !bad_len_q && !hit_q && free_q;
		del_clr = fin_load && (req_q == REQ_DEL) && !bad_len_q && hit_q
			&& (hit_view_q == view_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			entry_valid_q <= '0;
			idx_q         <= '0;
			vld_s1        <= 1'b0;
			found_q       <= 1'b0;
			hit_q         <= 1'b0;
			free_q        <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= ram_re;
			if (in_acc) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
			end else begin
				if (ram_re) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (lk_take) begin
					found_q <= 1'b1;
				end
				if (ex_hit) begin
					hit_q <= 1'b1;
				end
				if (vld_s1 && !ev_s1) begin
					free_q <= 1'b1;
				end
			end
			if (ram_we) begin
				entry_valid_q[free_idx_q] <= 1'b1;
			end
			if (del_clr) begin
				entry_valid_q[hit_idx_q] <= 1'b0;
			end
			if (fin_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		ev_s1  <= entry_valid_q[idx_q];
		if (in_acc) begin
			req_q     <= req.req_type;
			key_q     <= (req.req_type == REQ_LOOKUP) ? in_addr : (in_addr & len_mask(in_len));
			len_q     <= in_len;
			view_q    <= req.view_id;
			bad_len_q <= in_bad_len;
		end
		if (lk_take) begin
			best_len_q  <= ent_len;
			best_view_q <= ent_view;
		end
		if (ex_hit) begin
			hit_idx_q  <= idx_s1;
			hit_view_q <= ent_view;
		end
		if (vld_s1 && !ev_s1 && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (fin_load) begin
			out_status_q <= fin_status;
			out_found_q  <= fin_found;
			out_view_q   <= fin_view;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.found       = out_found_q;
	assign rsp.result_view = out_view_q;

`ifndef ASSERT_OFF
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !req.ready)
		else $error("request taken while previous request in progress");

	a_add_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> entry_valid_q[$past(free_idx_q)])
		else $error("added entry not marked valid");

	a_del_clears_valid: assert property (@(posedge clk) disable iff (!arst_n)
		del_clr |=> !entry_valid_q[$past(hit_idx_q)])
		else $error("deleted entry still valid");

	a_no_dup_entries: assert property (@(posedge clk) disable iff (!arst_n)
		(ex_hit && !in_acc) |-> !hit_q)
		else $error("two valid entries hold the same prefix");
`endif

endmodule
